// ----- src/kwc_pkg.sv -----
// shared types, constants and helper functions for the keyword word counter
package kwc_pkg;

    // item and word geometry
    localparam int TEXT_BITS      = 8;
    localparam int WORD_BYTES     = 8;
    localparam int WORD_BITS      = WORD_BYTES * TEXT_BITS;
    localparam int LEN_BITS       = 4;
    localparam int OUT_COUNT_BITS = 32;
    localparam int MATCH_BITS     = 3;
    localparam int CFG_INDEX_BITS = 3;

    // defaults for the top-level parameters
    localparam int KEYWORD_SLOTS_DEF = 7;
    localparam int COUNT_BITS_DEF    = 32;

    // word length codes
    localparam logic [LEN_BITS-1:0] LEN_EMPTY = LEN_BITS'(0);
    localparam logic [LEN_BITS-1:0] LEN_FULL  = LEN_BITS'(WORD_BYTES);
    localparam logic [LEN_BITS-1:0] LEN_LONG  = LEN_BITS'(WORD_BYTES + 1);

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEYWORD_COUNT = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEYWORD_BASE  = CFG_INDEX_BITS'(1);

    // word delimiters
    localparam logic [TEXT_BITS-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [TEXT_BITS-1:0] CHAR_PERIOD   = 8'h2E;
    localparam logic [TEXT_BITS-1:0] CHAR_COMMA    = 8'h2C;
    localparam logic [TEXT_BITS-1:0] CHAR_QUESTION = 8'h3F;
    localparam logic [TEXT_BITS-1:0] CHAR_EXCLAIM  = 8'h21;
    localparam logic [TEXT_BITS-1:0] CHAR_NEWLINE  = 8'h0A;

    // current word: packed text, low byte first, and its length
    typedef struct packed {
        logic [WORD_BITS-1:0] text;
        logic [LEN_BITS-1:0]  length;
    } word_t;

    // true for a byte that ends a word
    function automatic logic is_delim(input logic [TEXT_BITS-1:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_PERIOD) || (c == CHAR_COMMA) ||
               (c == CHAR_QUESTION) || (c == CHAR_EXCLAIM) || (c == CHAR_NEWLINE);
    endfunction

    // keyword length: position of the highest nonzero byte plus one
    function automatic logic [LEN_BITS-1:0] key_length(input logic [WORD_BITS-1:0] k);
        logic [LEN_BITS-1:0] n;
        n = LEN_EMPTY;
        for (int i = 0; i < WORD_BYTES; i++)
        begin
            if (k[i*TEXT_BITS +: TEXT_BITS] != '0)
            begin
                n = LEN_BITS'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ----- src/keyword_word_counter.sv -----
// top level of the keyword word counter: input stage, word state, counters, result register
//
// Takes one text byte per item and returns one result per item. A new item is
// accepted every clock cycle while the output side keeps up; an item passes the
// input register and then the result register. The rate is set by the single
// update of the word buffer and counters per item, which sits between those two
// registers together with the bank of keyword compares. The user must write
// keyword registers through the cfg port while no item is in flight; not enforced.
module keyword_word_counter #(
    parameter int KEYWORD_SLOTS = kwc_pkg::KEYWORD_SLOTS_DEF,
    parameter int COUNT_BITS    = kwc_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,  // [7:0] text_char
    input  logic                                 s_tuser,  // [0] clear_counts
    // result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [31:0] total_words, [63:32] keyword_hits, [95:64] other_words,
    // [96] word_closed, [99:97] slots_matched, [103:100] zero
    output logic [103:0]                         m_tdata,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [kwc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [kwc_pkg::WORD_BITS-1:0]        cfg_data
);

    localparam int EXT_BITS = (COUNT_BITS > kwc_pkg::OUT_COUNT_BITS) ?
                              COUNT_BITS : kwc_pkg::OUT_COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration registers
    logic [kwc_pkg::MATCH_BITS-1:0]                        keyword_count_reg;
    logic [KEYWORD_SLOTS-1:0][kwc_pkg::WORD_BITS-1:0]      keyword_reg;
    logic [KEYWORD_SLOTS-1:0][kwc_pkg::LEN_BITS-1:0]       key_len_reg;

    // input stage
    logic                           in_valid_reg;
    logic [kwc_pkg::TEXT_BITS-1:0]  char_reg;
    logic                           clear_reg;

    // word and counter state
    kwc_pkg::word_t                 word_reg;
    kwc_pkg::word_t                 word_next;
    logic [COUNT_BITS-1:0]          total_reg;
    logic [COUNT_BITS-1:0]          total_next;
    logic [COUNT_BITS-1:0]          hits_reg;
    logic [COUNT_BITS-1:0]          hits_next;
    logic [COUNT_BITS-1:0]          other_reg;
    logic [COUNT_BITS-1:0]          other_next;

    // result register
    logic                           out_valid_reg;
    logic                           closed_reg;
    logic                           closed_next;
    logic [kwc_pkg::MATCH_BITS-1:0] slots_reg;
    logic [kwc_pkg::MATCH_BITS-1:0] slots_next;

    // working values
    logic                           advance;
    kwc_pkg::word_t                 cur_word;
    logic [COUNT_BITS-1:0]          cur_total;
    logic [COUNT_BITS-1:0]          cur_hits;
    logic [COUNT_BITS-1:0]          cur_other;
    logic [kwc_pkg::MATCH_BITS-1:0] matched;
    logic [COUNT_BITS:0]            total_sum;
    logic [COUNT_BITS:0]            hits_sum;
    logic [COUNT_BITS:0]            other_sum;
    logic [EXT_BITS-1:0]            total_ext;
    logic [EXT_BITS-1:0]            hits_ext;
    logic [EXT_BITS-1:0]            other_ext;

    // handshake: input stage moves on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keyword_count_reg <= '0;
            keyword_reg       <= '0;
            key_len_reg       <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == kwc_pkg::REG_KEYWORD_COUNT)
            begin
                keyword_count_reg <= cfg_data[kwc_pkg::MATCH_BITS-1:0];
            end
            for (int i = 0; i < KEYWORD_SLOTS; i++)
            begin
                if (cfg_index == kwc_pkg::REG_KEYWORD_BASE + kwc_pkg::CFG_INDEX_BITS'(i))
                begin
                    keyword_reg[i] <= cfg_data;
                    key_len_reg[i] <= kwc_pkg::key_length(cfg_data);
                end
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg  <= s_tdata;
            clear_reg <= s_tuser;
        end
    end

    // clear applies before the byte is handled
    always_comb
    begin
        if (clear_reg)
        begin
            cur_word  = '0;
            cur_total = '0;
            cur_hits  = '0;
            cur_other = '0;
        end
        else
        begin
            cur_word  = word_reg;
            cur_total = total_reg;
            cur_hits  = hits_reg;
            cur_other = other_reg;
        end
    end

    kwc_match #(
        .KEYWORD_SLOTS (KEYWORD_SLOTS)
    ) u_match (
        .word          (cur_word),
        .keywords      (keyword_reg),
        .key_lengths   (key_len_reg),
        .keyword_count (keyword_count_reg),
        .matched       (matched)
    );

    // saturating sums, carry out means past the limit
    assign total_sum = {1'b0, cur_total} + (COUNT_BITS+1)'(1);
    assign hits_sum  = {1'b0, cur_hits} + (COUNT_BITS+1)'(matched);
    assign other_sum = {1'b0, cur_other} + (COUNT_BITS+1)'(1);

    // word and counter update for one byte
    always_comb
    begin
        word_next   = cur_word;
        total_next  = cur_total;
        hits_next   = cur_hits;
        other_next  = cur_other;
        closed_next = 1'b0;
        slots_next  = '0;
        if (kwc_pkg::is_delim(char_reg))
        begin
            if (cur_word.length != kwc_pkg::LEN_EMPTY)
            begin
                closed_next = 1'b1;
                slots_next  = matched;
                total_next  = total_sum[COUNT_BITS] ? COUNT_MAX : total_sum[COUNT_BITS-1:0];
                hits_next   = hits_sum[COUNT_BITS] ? COUNT_MAX : hits_sum[COUNT_BITS-1:0];
                if (matched == '0)
                begin
                    other_next = other_sum[COUNT_BITS] ?
                                 COUNT_MAX : other_sum[COUNT_BITS-1:0];
                end
            end
            word_next = '0;
        end
        else if (cur_word.length < kwc_pkg::LEN_FULL)
        begin
            for (int i = 0; i < kwc_pkg::WORD_BYTES; i++)
            begin
                if (cur_word.length == kwc_pkg::LEN_BITS'(i))
                begin
                    word_next.text[i*kwc_pkg::TEXT_BITS +: kwc_pkg::TEXT_BITS] = char_reg;
                end
            end
            word_next.length = cur_word.length + kwc_pkg::LEN_BITS'(1);
        end
        else
        begin
            word_next.length = kwc_pkg::LEN_LONG;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= '0;
            total_reg <= '0;
            hits_reg  <= '0;
            other_reg <= '0;
        end
        else if (advance)
        begin
            word_reg  <= word_next;
            total_reg <= total_next;
            hits_reg  <= hits_next;
            other_reg <= other_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            closed_reg <= closed_next;
            slots_reg  <= slots_next;
        end
    end

    // counters go out in their low 32 bits
    assign total_ext = EXT_BITS'(total_reg);
    assign hits_ext  = EXT_BITS'(hits_reg);
    assign other_ext = EXT_BITS'(other_reg);

    assign m_tdata = {4'b0000, slots_reg, closed_reg,
                      other_ext[kwc_pkg::OUT_COUNT_BITS-1:0],
                      hits_ext[kwc_pkg::OUT_COUNT_BITS-1:0],
                      total_ext[kwc_pkg::OUT_COUNT_BITS-1:0]};

endmodule

// ----- src/kwc_match.sv -----
// compare bank: counts the active keyword slots equal to a closed word
module kwc_match #(
    parameter int KEYWORD_SLOTS = kwc_pkg::KEYWORD_SLOTS_DEF
) (
    input  kwc_pkg::word_t                                         word,
    input  logic [KEYWORD_SLOTS-1:0][kwc_pkg::WORD_BITS-1:0]       keywords,
    input  logic [KEYWORD_SLOTS-1:0][kwc_pkg::LEN_BITS-1:0]        key_lengths,
    input  logic [kwc_pkg::MATCH_BITS-1:0]                         keyword_count,
    output logic [kwc_pkg::MATCH_BITS-1:0]                         matched
);

    logic [KEYWORD_SLOTS-1:0] hit;

    // one compare per slot, long words never match
    always_comb
    begin
        for (int i = 0; i < KEYWORD_SLOTS; i++)
        begin
            hit[i] = (kwc_pkg::MATCH_BITS'(i) < keyword_count) &&
                     (word.length <= kwc_pkg::LEN_FULL) &&
                     (keywords[i] == word.text) &&
                     (key_lengths[i] == word.length);
        end
    end

    // population count of slot hits
    always_comb
    begin
        matched = '0;
        for (int i = 0; i < KEYWORD_SLOTS; i++)
        begin
            matched = matched + kwc_pkg::MATCH_BITS'(hit[i]);
        end
    end

endmodule
